[sv/m4te_pkg.sv]
// Package for the 4x4 fixed-point transform engine.
// Holds the request and response payload types, request codes and state encoding.
// No dependencies.
`default_nettype none

package m4te_pkg;

  localparam int DIM    = 4;
  localparam int ELEM_W = 32;
  localparam int ROW_W  = DIM * ELEM_W;

  typedef enum logic [2:0] {
    REQ_IDENTITY  = 3'd0,
    REQ_OPERAND   = 3'd1,
    REQ_WRITE     = 3'd2,
    REQ_READ      = 3'd3,
    REQ_TRANSPOSE = 3'd4
  } req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RD,
    ST_TRD,
    ST_TWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [1:0]         row_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
  } req_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] out0;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic signed [31:0] out3;
  } rsp_t;

endpackage

`default_nettype wire

[sv/matrix4_transform_engine.sv]
// Top level of the 4x4 fixed-point transform engine: matrix and accumulator memories,
// request sequencer and the four-lane multiply-accumulate pipeline.
// Depends on m4te_pkg.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid, req_stall | req_t: request code, row, four elements
//   rsp     | out       | rsp_valid, rsp_stall | rsp_t: status, four row elements
//
// Identity, write row, dropped operand rows and unused codes go straight to completion;
// a read row first passes a read state. An operand row reads one matrix row per cycle
// through the single read port of each memory, then multiply and accumulate stages.
// A transpose does four row reads and four row writes on the matrix memory.
// Reset takes effect at once through per-row valid bits; there is no clearing pass.
// A stalled response holds in the output register while the next request is taken.
`default_nettype none

module matrix4_transform_engine
  import m4te_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  wire  rsp_stall,
  output rsp_t rsp
);

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam int PRD_W = 2 * ELEM_W;
  localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

  function automatic logic [ROW_W-1:0] ident_row(input logic [1:0] r);
    logic [ROW_W-1:0] v;
    v = '0;
    v[ELEM_W*r +: ELEM_W] = ONE;
    return v;
  endfunction

  function automatic logic [ELEM_W-1:0] sat32(input logic [ACC_W-1:0] s);
    logic [ACC_W-32:0] upper;
    upper = s[ACC_W-1:31];
    if ((&upper) || !(|upper)) begin
      return s[ELEM_W-1:0];
    end
    return s[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  logic [ROW_W-1:0]       m_mem [DIM];
  logic [DIM*ACC_W-1:0]   a_mem [DIM];
  logic [ROW_W-1:0]       m_q;
  logic [DIM*ACC_W-1:0]   a_q;

  logic                   m_we, m_re, a_we, a_re;
  logic [1:0]             m_waddr, m_raddr, a_waddr, a_raddr;
  logic [ROW_W-1:0]       m_wdata;
  logic [DIM*ACC_W-1:0]   a_wdata;

  state_t                 state, state_next;
  logic [2:0]             cnt;
  logic [DIM-1:0]         m_valid, a_valid;
  logic [1:0]             expected;
  logic [1:0]             k;
  logic signed [31:0]     b [DIM];
  logic                   v1, v2;
  logic [1:0]             row1, row2;
  logic signed [PRD_W-1:0] prod [DIM];
  logic [ACC_W-1:0]       acc_hold [DIM];
  logic [ACC_W-1:0]       sum [DIM];
  logic [ELEM_W-1:0]      tbuf [DIM][DIM];
  logic [1:0]             rd_row;
  logic                   res_status;
  logic [ROW_W-1:0]       res_out;

  logic                   req_accept;
  logic                   operand_ok;
  logic                   rsp_load;
  logic [ROW_W-1:0]       m_row1;
  logic signed [31:0]     m_sel;
  logic [1:0]             trow;

  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign operand_ok = (req.row_index == expected);
  assign rsp_load   = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign trow       = cnt[1:0] - 2'd1;

  always_ff @(posedge clk) begin
    if (m_we) begin
      m_mem[m_waddr] <= m_wdata;
    end
    if (m_re) begin
      m_q <= m_mem[m_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= a_wdata;
    end
    if (a_re) begin
      a_q <= a_mem[a_raddr];
    end
  end

  always_comb begin
    m_row1 = m_valid[row1] ? m_q : ident_row(row1);
    m_sel  = m_row1[ELEM_W*k +: ELEM_W];
    for (int j = 0; j < DIM; j++) begin
      sum[j] = acc_hold[j] + {{2{prod[j][PRD_W-1]}}, prod[j][PRD_W-1:FRAC_BITS]};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_accept) begin
          case (req.req_type)
            REQ_OPERAND:   state_next = operand_ok ? ST_MUL : ST_DONE;
            REQ_READ:      state_next = ST_RD;
            REQ_TRANSPOSE: state_next = ST_TRD;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        if (v2 && row2 == 2'd3) begin
          state_next = ST_DONE;
        end
      end
      ST_RD:   state_next = ST_DONE;
      ST_TRD: begin
        if (cnt == 3'd4) begin
          state_next = ST_TWR;
        end
      end
      ST_TWR: begin
        if (cnt[1:0] == 2'd3) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    m_we    = 1'b0;
    m_re    = 1'b0;
    a_we    = 1'b0;
    a_re    = 1'b0;
    m_waddr = req.row_index;
    m_raddr = req.row_index;
    a_waddr = row2;
    a_raddr = cnt[1:0];
    m_wdata = {req.elem3, req.elem2, req.elem1, req.elem0};
    a_wdata = '0;
    for (int j = 0; j < DIM; j++) begin
      a_wdata[ACC_W*j +: ACC_W] = sum[j];
    end
    case (state)
      ST_IDLE: begin
        m_we = req_accept && (req.req_type == REQ_WRITE);
        m_re = req_accept && (req.req_type == REQ_READ);
      end
      ST_MUL: begin
        m_re    = !cnt[2];
        a_re    = !cnt[2];
        m_raddr = cnt[1:0];
        m_waddr = row2;
        m_we    = v2 && (k == 2'd3);
        a_we    = v2 && (k != 2'd3);
        for (int j = 0; j < DIM; j++) begin
          m_wdata[ELEM_W*j +: ELEM_W] = sat32(sum[j]);
        end
      end
      ST_TRD: begin
        m_re    = !cnt[2];
        m_raddr = cnt[1:0];
      end
      ST_TWR: begin
        m_we    = 1'b1;
        m_waddr = cnt[1:0];
        for (int i = 0; i < DIM; i++) begin
          m_wdata[ELEM_W*i +: ELEM_W] = tbuf[i][cnt[1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      m_valid   <= '0;
      a_valid   <= '0;
      expected  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 3'd0 : cnt + 3'd1;
      v1    <= (state == ST_MUL) && !cnt[2];
      v2    <= v1;
      if (m_we) begin
        m_valid[m_waddr] <= 1'b1;
      end
      if (a_we) begin
        a_valid[a_waddr] <= 1'b1;
      end
      if (req_accept) begin
        case (req.req_type)
          REQ_IDENTITY: begin
            m_valid  <= '0;
            a_valid  <= '0;
            expected <= '0;
          end
          REQ_WRITE, REQ_TRANSPOSE: begin
            a_valid  <= '0;
            expected <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_MUL && v2 && row2 == 2'd3) begin
        if (k == 2'd3) begin
          a_valid  <= '0;
          expected <= '0;
        end else begin
          expected <= k + 2'd1;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      k          <= req.row_index;
      rd_row     <= req.row_index;
      b[0]       <= req.elem0;
      b[1]       <= req.elem1;
      b[2]       <= req.elem2;
      b[3]       <= req.elem3;
      res_status <= (req.req_type == REQ_OPERAND) && !operand_ok;
      res_out    <= '0;
    end
    row1 <= cnt[1:0];
    row2 <= row1;
    for (int j = 0; j < DIM; j++) begin
      prod[j]     <= m_sel * b[j];
      acc_hold[j] <= a_valid[row1] ? a_q[ACC_W*j +: ACC_W] : '0;
    end
    if (state == ST_RD) begin
      res_out <= m_valid[rd_row] ? m_q : ident_row(rd_row);
    end
    if (state == ST_TRD && cnt != 3'd0) begin
      for (int j = 0; j < DIM; j++) begin
        tbuf[trow][j] <= m_valid[trow] ? m_q[ELEM_W*j +: ELEM_W]
                                       : ((trow == 2'(j)) ? ONE : '0);
      end
    end
    if (rsp_load) begin
      rsp.status <= res_status;
      rsp.out0   <= res_out[0*ELEM_W +: ELEM_W];
      rsp.out1   <= res_out[1*ELEM_W +: ELEM_W];
      rsp.out2   <= res_out[2*ELEM_W +: ELEM_W];
      rsp.out3   <= res_out[3*ELEM_W +: ELEM_W];
    end
  end

  // A response is only ever launched from the completion state.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("response launched outside completion state");

  // The operand row being multiplied is always the one the sequence expects.
  a_mul_in_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (k == expected))
    else $error("operand row multiplied out of order");

  // The final operand row commits to the matrix and never writes the accumulators.
  a_commit_no_acc: assert property (@(posedge clk) disable iff (rst)
    a_we |-> (state == ST_MUL) && (k != 2'd3) && !m_we)
    else $error("accumulator written during commit");

  // Pipeline valid bits only run while a multiply pass is active.
  a_pipe_in_mul: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1) && (state == ST_MUL))
    else $error("multiply pipeline active outside multiply pass");

endmodule

`default_nettype wire
